// ----- src/nnr_pkg.sv -----
// Shared types and constants of the nearest-neighbour RGBA resampler.
package nnr_pkg;

   // Field widths fixed by the register and item formats
   localparam int DIM_W   = 13;
   localparam int COORD_W = 12;
   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 4 * BYTE_W;
   localparam int PROD_W  = 2 * DIM_W;
   localparam int DVD_W   = COORD_W + DIM_W;
   localparam int QUO_W   = DIM_W;
   localparam int STEP_W  = $clog2(QUO_W);
   localparam int CSR_IDX_W = 3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HEIGHT = 3'd4;

   // Item kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   // Channel codes
   localparam logic [2:0] DEFAULT_CHANNELS = 3'd3;
   localparam logic [2:0] MAX_CHANNELS     = 3'd4;
   localparam logic [2:0] GRAY_ALPHA       = 3'd2;
   localparam logic [BYTE_W-1:0] OPAQUE    = 8'hFF;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_CONFIG = 2'd1,
      STATUS_INCOMPLETE = 2'd2,
      STATUS_OUTSIDE    = 2'd3
   } status_type;

   typedef struct packed {
      logic               req_type;
      logic               start_of_image;
      logic [BYTE_W-1:0]  byte_zero;
      logic [BYTE_W-1:0]  byte_one;
      logic [BYTE_W-1:0]  byte_two;
      logic [BYTE_W-1:0]  byte_three;
      logic [COORD_W-1:0] target_x;
      logic [COORD_W-1:0] target_y;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] alpha;
      status_type        status;
   } rsp_payload_type;

   // Divider control and status
   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DIM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- src/nearest_neighbor_rgba_resampler.sv -----
// Top level of the nearest-neighbour RGBA8 resampler: sequencer, registers, expansion.
//
//   channel  ports                               direction  moves
//   req      req_valid req_ready req_payload     in         load or pixel request item
//   rsp      rsp_valid rsp_ready rsp_payload     out        RGBA8 result item and status
//   csr      csr_valid csr_ready csr_index/data  in         configuration register write
//
// Loads keep the sequencer idle; req_ready stays high across back-to-back loads.
// A pixel request drops req_ready through the check and finish states when it
// fails a check, else also through two divider runs of 13 quotient steps each, the
// multiplier steps and one store read. Its result is valid as ready returns, so a
// new request is taken only once the last one is done. Reset clears the state, the
// configuration registers, the result valid flag and the pixel count; the store and
// the payload registers are not cleared. A result waits in the output register
// while loads go on; a second request stalls in its last step until the first is taken.
module nearest_neighbor_rgba_resampler
   import nnr_pkg::*;
#(
   parameter int MAX_SOURCE_PIXELS = 65536,
   parameter int MAX_DIMENSION     = 4096
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   localparam int AW = (MAX_SOURCE_PIXELS > 1) ? $clog2(MAX_SOURCE_PIXELS) : 1;
   localparam int CW = $clog2(MAX_SOURCE_PIXELS + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVX_GO,
      ST_DIVX,
      ST_DIVY_GO,
      ST_DIVY,
      ST_INDEX,
      ST_ADDR,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [DIM_W-1:0]  src_w_ff, src_w_in;
   logic [DIM_W-1:0]  src_h_ff, src_h_in;
   logic [2:0]        chan_ff, chan_in;
   logic [DIM_W-1:0]  tgt_w_ff, tgt_w_in;
   logic [DIM_W-1:0]  tgt_h_ff, tgt_h_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;
   logic [COORD_W-1:0] tx_ff, tx_in;
   logic [COORD_W-1:0] ty_ff, ty_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DIM_W-1:0]  sx_ff, sx_in;
   logic [DIM_W-1:0]  sy_ff, sy_in;
   status_type        status_ff, status_in;
   logic              in_range_ff, in_range_in;

   logic              req_fire;
   logic              csr_fire;
   logic [CW-1:0]     base;
   logic              wr_en;
   logic              rd_en;
   logic [PROD_W-1:0] idx;
   logic              idx_ok;
   logic [WORD_W-1:0] rd_data;
   logic [WORD_W-1:0] word;
   logic [DIM_W-1:0]  mul_a;
   logic [DIM_W-1:0]  mul_b;
   logic              mul_en;
   logic [2:0]        chan_eff;
   logic              bad_config;
   logic [DIM_W-1:0]  src_max;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;

   // Load path: restart on start of image, drop loads past the store
   assign base  = req_payload.start_of_image ? '0 : count_ff;
   assign wr_en = req_fire && req_payload.req_type == REQ_LOAD
                  && 32'(base) < MAX_SOURCE_PIXELS;

   // Configuration checks
   assign chan_eff   = (chan_ff == '0) ? DEFAULT_CHANNELS : chan_ff;
   assign bad_config = src_w_ff == '0 || 32'(src_w_ff) > MAX_DIMENSION
                    || src_h_ff == '0 || 32'(src_h_ff) > MAX_DIMENSION
                    || chan_eff > MAX_CHANNELS
                    || tgt_w_ff == '0 || 32'(tgt_w_ff) > MAX_DIMENSION
                    || tgt_h_ff == '0 || 32'(tgt_h_ff) > MAX_DIMENSION;

   // Pick shared multiplier operands per step
   always_comb begin
      mul_en = 1'b0;
      mul_a  = src_w_ff;
      mul_b  = src_h_ff;
      case (state_ff)
         ST_IDLE: begin
            mul_en = req_fire && req_payload.req_type == REQ_PIXEL;
         end
         ST_CHECK: begin
            mul_en = 1'b1;
            mul_a  = DIM_W'(tx_ff);
            mul_b  = src_w_ff;
         end
         ST_DIVX_GO: begin
            mul_en = 1'b1;
            mul_a  = DIM_W'(ty_ff);
            mul_b  = src_h_ff;
         end
         ST_INDEX: begin
            mul_en = 1'b1;
            mul_a  = sy_ff;
            mul_b  = src_w_ff;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // Feed the divider from the product register
   always_comb begin
      div_req.start    = state_ff == ST_DIVX_GO || state_ff == ST_DIVY_GO;
      div_req.dividend = prod_ff[DVD_W-1:0];
      div_req.divisor  = (state_ff == ST_DIVX_GO) ? tgt_w_ff : tgt_h_ff;
   end

   nnr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Flat source index and its store read
   assign idx    = prod_ff + PROD_W'(sx_ff);
   assign idx_ok = 32'(idx) < MAX_SOURCE_PIXELS;
   assign rd_en  = state_ff == ST_ADDR && idx_ok;

   nnr_pixel_store #(
      .DEPTH (MAX_SOURCE_PIXELS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (base[AW-1:0]),
      .wr_data ({req_payload.byte_three, req_payload.byte_two,
                 req_payload.byte_one, req_payload.byte_zero}),
      .rd_en   (rd_en),
      .rd_addr (idx[AW-1:0]),
      .rd_data (rd_data)
   );

   assign word    = in_range_ff ? rd_data : '0;
   assign src_max = (state_ff == ST_DIVX) ? src_w_ff - DIM_W'(1) : src_h_ff - DIM_W'(1);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      src_w_in     = src_w_ff;
      src_h_in     = src_h_ff;
      chan_in      = chan_ff;
      tgt_w_in     = tgt_w_ff;
      tgt_h_in     = tgt_h_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      prod_in      = mul_en ? mul_a * mul_b : prod_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      status_in    = status_ff;
      in_range_in  = in_range_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes
      if (csr_fire) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  src_w_in = csr_data;
            CSR_SOURCE_HEIGHT: src_h_in = csr_data;
            CSR_CHANNEL_COUNT: chan_in  = csr_data[2:0];
            CSR_TARGET_WIDTH:  tgt_w_in = csr_data;
            CSR_TARGET_HEIGHT: tgt_h_in = csr_data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_payload.req_type == REQ_LOAD) begin
                  count_in = wr_en ? base + CW'(1) : base;
               end else begin
                  tx_in    = req_payload.target_x;
                  ty_in    = req_payload.target_y;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // product holds source area here
            if (bad_config) begin
               status_in = STATUS_BAD_CONFIG;
               state_in  = ST_FINISH;
            end else if (32'(count_ff) < 32'(prod_ff)) begin
               status_in = STATUS_INCOMPLETE;
               state_in  = ST_FINISH;
            end else if (DIM_W'(tx_ff) >= tgt_w_ff || DIM_W'(ty_ff) >= tgt_h_ff) begin
               status_in = STATUS_OUTSIDE;
               state_in  = ST_FINISH;
            end else begin
               status_in = STATUS_OK;
               state_in  = ST_DIVX_GO;
            end
         end
         ST_DIVX_GO: begin
            state_in = ST_DIVX;
         end
         ST_DIVX: begin
            if (div_rsp.done) begin
               sx_in    = (div_rsp.quotient > src_max) ? src_max : div_rsp.quotient;
               state_in = ST_DIVY_GO;
            end
         end
         ST_DIVY_GO: begin
            state_in = ST_DIVY;
         end
         ST_DIVY: begin
            if (div_rsp.done) begin
               sy_in    = (div_rsp.quotient > src_max) ? src_max : div_rsp.quotient;
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            in_range_in = idx_ok;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = status_ff;
               if (status_ff != STATUS_OK) begin
                  rsp_in.red   = '0;
                  rsp_in.green = '0;
                  rsp_in.blue  = '0;
                  rsp_in.alpha = '0;
               end else if (chan_eff <= GRAY_ALPHA) begin
                  rsp_in.red   = word[7:0];
                  rsp_in.green = word[7:0];
                  rsp_in.blue  = word[7:0];
                  rsp_in.alpha = (chan_eff == GRAY_ALPHA) ? word[15:8] : OPAQUE;
               end else begin
                  rsp_in.red   = word[7:0];
                  rsp_in.green = word[15:8];
                  rsp_in.blue  = word[23:16];
                  rsp_in.alpha = (chan_eff == MAX_CHANNELS) ? word[31:24] : OPAQUE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_w_ff     <= '0;
         src_h_ff     <= '0;
         chan_ff      <= '0;
         tgt_w_ff     <= '0;
         tgt_h_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_w_ff     <= src_w_in;
         src_h_ff     <= src_h_in;
         chan_ff      <= chan_in;
         tgt_w_ff     <= tgt_w_in;
         tgt_h_ff     <= tgt_h_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      prod_ff     <= prod_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      status_ff   <= status_in;
      in_range_ff <= in_range_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_OK |->
         rsp_ff.red == '0 && rsp_ff.green == '0 && rsp_ff.blue == '0
         && rsp_ff.alpha == '0)
      else $error("error result carries colour bytes");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_SOURCE_PIXELS)
      else $error("pixel count beyond store depth");

   a_read_loaded: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> 32'(idx) < 32'(count_ff))
      else $error("store read of an unloaded pixel");

   a_request_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.req_type == REQ_PIXEL |=> !req_ready)
      else $error("ready during pixel request");

endmodule

// ----- src/nnr_divider.sv -----
// Iterative restoring divider shared by both coordinate mappings.
module nnr_divider
   import nnr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIM_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  low_ff, low_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [DIM_W-1:0]  divisor_ff, divisor_in;
   logic [DIM_W:0]    shifted;
   logic              fits;

   // One quotient bit a cycle; the quotient is known to fit QUO_W bits,
   // so the top dividend bits seed the remainder directly
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      shifted    = {rem_ff, low_ff[QUO_W-1]};
      fits       = shifted >= {1'b0, divisor_ff};
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = DIM_W'(div_req.dividend[DVD_W-1:QUO_W]);
         low_in     = div_req.dividend[QUO_W-1:0];
         quo_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? DIM_W'(shifted - {1'b0, divisor_ff}) : shifted[DIM_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         low_in  = {low_ff[QUO_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> div_req.divisor != '0)
      else $error("divider started with zero divisor");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a finished run");

endmodule

// ----- src/nnr_pixel_store.sv -----
// Source pixel store: one write port, one registered read port.
module nnr_pixel_store
   import nnr_pkg::*;
#(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
)
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];

   // Write one pixel
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one pixel, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
